### rtl/mmp_pkg.sv
package mmp_pkg;

  localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
  localparam logic [3:0] KIND_AFTERTCH  = 4'hA;
  localparam logic [3:0] KIND_CTRL_CHG  = 4'hB;
  localparam logic [3:0] KIND_PROG_CHG  = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRES = 4'hD;
  localparam logic [3:0] KIND_PITCH_BND = 4'hE;
  localparam logic [3:0] KIND_SYSTEM    = 4'hF;

  localparam logic [1:0] NEED_ONE = 2'd1;
  localparam logic [1:0] NEED_TWO = 2'd2;

  typedef logic [7:0] midi_byte_t;
  typedef logic [6:0] midi_data_t;

  // message types that produce a result
  function automatic logic kind_reported(input logic [3:0] kind);
    return (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON) ||
           (kind == KIND_CTRL_CHG) || (kind == KIND_CHAN_PRES) ||
           (kind == KIND_PITCH_BND);
  endfunction

  // data bytes a channel message needs
  function automatic logic [1:0] kind_need(input logic [3:0] kind);
    return ((kind == KIND_AFTERTCH) || (kind == KIND_PROG_CHG) ||
            (kind == KIND_CHAN_PRES)) ? NEED_ONE : NEED_TWO;
  endfunction

endpackage

### rtl/midi_message_parser.sv
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_ready | in_rx_byte[7:0]
// out_    | output    | out_valid/out_ready | out_status_byte[7:0], out_first_data[6:0],
//         |           |                     | out_second_data[6:0]
//
// one byte per cycle unless a stalled result holds the input register; a byte passes
// an input register, then the parse logic writes the result register.
// rst_n is synchronous and clears running status, counts and both valid flags.
// a stalled result holds the input register only when that byte would produce a
// result too; other bytes keep flowing past a waiting result.
module midi_message_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmp_pkg::midi_byte_t in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output mmp_pkg::midi_byte_t out_status_byte,
  output mmp_pkg::midi_data_t out_first_data,
  output mmp_pkg::midi_data_t out_second_data
);
  import mmp_pkg::*;

  logic       s1_valid_r;
  midi_byte_t s1_byte_r;

  midi_byte_t running_status_r, running_status_nxt;
  logic [1:0] bytes_needed_r, bytes_needed_nxt;
  logic [1:0] bytes_seen_r, bytes_seen_nxt;
  midi_data_t held_first_r, held_first_nxt;

  logic       out_valid_r;
  midi_byte_t out_status_r;
  midi_data_t out_first_r, out_second_r;

  logic       emit;
  logic       advance;
  logic [1:0] seen_now;
  midi_data_t first_val;

  assign seen_now  = bytes_seen_r + 2'd1;
  assign first_val = (bytes_seen_r == 2'd0) ? s1_byte_r[6:0] : held_first_r;

  always_comb begin
    running_status_nxt = running_status_r;
    bytes_needed_nxt   = bytes_needed_r;
    bytes_seen_nxt     = bytes_seen_r;
    held_first_nxt     = held_first_r;
    emit               = 1'b0;
    priority if (s1_byte_r[7:4] == KIND_SYSTEM) begin
      // system and realtime bytes leave everything alone
    end else if (s1_byte_r[7]) begin
      running_status_nxt = s1_byte_r;
      bytes_seen_nxt     = 2'd0;
      bytes_needed_nxt   = kind_need(s1_byte_r[7:4]);
    end else if (running_status_r != 8'h00) begin
      held_first_nxt = first_val;
      if ((seen_now < bytes_needed_r) && (bytes_seen_r < bytes_needed_r)) begin
        bytes_seen_nxt = seen_now;
      end else begin
        bytes_seen_nxt = 2'd0;
        emit           = kind_reported(running_status_r[7:4]);
      end
    end else begin
      // data with no status held is dropped
    end
  end

  // a byte that makes no result never waits on the output side
  assign advance  = s1_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      running_status_r <= 8'h00;
      bytes_needed_r   <= 2'd0;
      bytes_seen_r     <= 2'd0;
      held_first_r     <= 7'd0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        running_status_r <= running_status_nxt;
        bytes_needed_r   <= bytes_needed_nxt;
        bytes_seen_r     <= bytes_seen_nxt;
        held_first_r     <= held_first_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance && emit) begin
      out_status_r <= running_status_r;
      if (bytes_needed_r == NEED_ONE) begin
        out_first_r  <= s1_byte_r[6:0];
        out_second_r <= 7'd0;
      end else begin
        out_first_r  <= first_val;
        out_second_r <= s1_byte_r[6:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_byte = out_status_r;
  assign out_first_data  = out_first_r;
  assign out_second_data = out_second_r;

endmodule

### rtl/mmp_checker.sv
module mmp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mmp_pkg::midi_byte_t in_rx_byte,
  input logic                out_valid,
  input logic                out_ready,
  input mmp_pkg::midi_byte_t out_status_byte,
  input mmp_pkg::midi_data_t out_first_data,
  input mmp_pkg::midi_data_t out_second_data
);
  import mmp_pkg::*;

  // nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status_byte) &&
      $stable(out_first_data) && $stable(out_second_data))
    else $error("stalled result changed");

  // only reportable channel types leave the block
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status_byte[7:4] == KIND_NOTE_OFF ||
      out_status_byte[7:4] == KIND_NOTE_ON || out_status_byte[7:4] == KIND_CTRL_CHG ||
      out_status_byte[7:4] == KIND_CHAN_PRES || out_status_byte[7:4] == KIND_PITCH_BND)
    else $error("unreported message type emitted");

  // channel pressure carries a single data byte
  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_byte[7:4] == KIND_CHAN_PRES |-> out_second_data == 7'd0)
    else $error("second data nonzero on one-byte message");

  // a result needs at least two byte transfers before it, status and data
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) && !$past(in_rx_byte[7], 2))
    else $error("result without a data byte transfer");

endmodule

bind midi_message_parser mmp_checker u_mmp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_rx_byte      (in_rx_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status_byte (out_status_byte),
  .out_first_data  (out_first_data),
  .out_second_data (out_second_data)
);
